FILE: hw/rtl/lfr_pkg.sv
// Shared types and constants for the LRU frame replacer.
// Used by the controller, the datapath and the top level; no dependencies.
package lfr_pkg;

    localparam int FRAMES_DEFAULT = 16;
    localparam int OPCODE_W       = 2;
    localparam int FRAME_W        = 4;
    localparam int COUNT_W        = 5;
    localparam int CAP_W          = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic [OPCODE_W-1:0] OP_VICTIM = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_PIN    = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_UNPIN  = 2'd2;

    typedef struct packed {
        logic load;
        logic read;
        logic victim;
        logic pin;
        logic unpin;
        logic finish;
    } lfr_cmd_t;

    typedef struct packed {
        logic [OPCODE_W-1:0] op;
        logic                hit;
        logic                free;
        logic                empty;
        logic                room;
    } lfr_status_t;

endpackage

FILE: hw/rtl/lru_frame_replacer_unit.sv
// LRU frame replacer top level: one request per start beat while not busy.
// Each request is loaded, its links are read from the registered link RAMs in
// S_READ, the list is updated in S_UPDATE, and the commit registers done.
// The receiver cannot stall; each result is shown for one cycle on done.
// Reset empties the list and sets capacity to 16; no clearing pass is needed.
// Depends on lfr_pkg, lfr_ctrl and lfr_datapath.
module lru_frame_replacer_unit #(
    parameter int FRAMES = lfr_pkg::FRAMES_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [lfr_pkg::OPCODE_W-1:0]  opcode,
    input  logic [lfr_pkg::FRAME_W-1:0]   frame,
    output logic                          done,
    output logic                          found,
    output logic [lfr_pkg::FRAME_W-1:0]   victim_frame,
    output logic [lfr_pkg::COUNT_W-1:0]   count,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import lfr_pkg::*;

    lfr_cmd_t         cmd;
    lfr_status_t      status;
    logic [CAP_W-1:0] cap_reg;
    logic             cap_sel;

    assign cap_sel = (paddr[2] == 1'b0);
    assign pready  = 1'b1;
    assign prdata  = cap_sel ? 32'(cap_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
        end
        else if (psel && penable && pwrite && pready && cap_sel)
        begin
            cap_reg <= pwdata[CAP_W-1:0];
        end
    end

    lfr_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    lfr_datapath #(.FRAMES(FRAMES)) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .opcode       (opcode),
        .frame        (frame),
        .capacity     (cap_reg),
        .done         (done),
        .found        (found),
        .victim_frame (victim_frame),
        .count        (count)
    );

endmodule

FILE: hw/rtl/lfr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lfr_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/lfr_ctrl.sv
// Request sequencer for the LRU frame replacer: load, link read, commit.
// Depends on lfr_pkg for the command and status structs and the opcodes.
module lfr_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  lfr_pkg::lfr_status_t status,
    output lfr_pkg::lfr_cmd_t   cmd,
    output logic                busy
);
    import lfr_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_READ   = 2'd1;
    localparam logic [1:0] S_UPDATE = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                cmd.read   = 1'b1;
                state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                cmd.finish = 1'b1;
                cmd.victim = (status.op == OP_VICTIM) && !status.empty;
                cmd.pin    = (status.op == OP_PIN) && status.hit;
                cmd.unpin  = (status.op == OP_UNPIN) && status.free && status.room;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    a_load_then_read: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> state_reg == S_READ)
        else $error("Accepted request did not move to the link read.");

    a_read_then_update: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_READ |=> cmd.finish)
        else $error("Link read was not followed by a commit.");

    a_one_action: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.victim, cmd.pin, cmd.unpin}))
        else $error("More than one list action in a commit.");

endmodule

FILE: hw/rtl/lfr_datapath.sv
// Datapath of the LRU frame replacer: doubly linked age list in two link RAMs,
// head, tail, length and listed flags. Depends on lfr_pkg and lfr_ram.
module lfr_datapath #(
    parameter int FRAMES = lfr_pkg::FRAMES_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  lfr_pkg::lfr_cmd_t             cmd,
    output lfr_pkg::lfr_status_t          status,
    input  logic [lfr_pkg::OPCODE_W-1:0]  opcode,
    input  logic [lfr_pkg::FRAME_W-1:0]   frame,
    input  logic [lfr_pkg::CAP_W-1:0]     capacity,
    output logic                          done,
    output logic                          found,
    output logic [lfr_pkg::FRAME_W-1:0]   victim_frame,
    output logic [lfr_pkg::COUNT_W-1:0]   count
);
    import lfr_pkg::*;

    localparam int FW = $clog2(FRAMES);
    localparam int LW = $clog2(FRAMES + 1);
    localparam int XW = (FW > FRAME_W ? FW : FRAME_W) + 1;
    localparam int MW = (LW > CAP_W ? LW : CAP_W) + 1;

    logic [OPCODE_W-1:0] op_reg;
    logic [FW-1:0]       frame_reg;
    logic                frame_ok_reg;
    logic [FW-1:0]       head_reg;
    logic [FW-1:0]       head_next;
    logic [FW-1:0]       tail_reg;
    logic [FW-1:0]       tail_next;
    logic [LW-1:0]       length_reg;
    logic [LW-1:0]       length_next;
    logic [FRAMES-1:0]   listed_reg;
    logic [FRAMES-1:0]   listed_next;
    logic                done_reg;
    logic                found_reg;
    logic [FRAME_W-1:0]  victim_reg;
    logic [COUNT_W-1:0]  count_reg;

    logic [FW-1:0] raddr;
    logic [FW-1:0] next_rd;
    logic [FW-1:0] prev_rd;
    logic          next_we;
    logic [FW-1:0] next_waddr;
    logic [FW-1:0] next_wdata;
    logic          prev_we;
    logic [FW-1:0] prev_waddr;
    logic [FW-1:0] prev_wdata;
    logic          empty;

    assign empty = (length_reg == '0);

    assign status.op    = op_reg;
    assign status.hit   = frame_ok_reg && listed_reg[frame_reg];
    assign status.free  = frame_ok_reg && !listed_reg[frame_reg];
    assign status.empty = empty;
    assign status.room  = (MW'(length_reg) < MW'(capacity)) &&
                          (length_reg < LW'(FRAMES));

    assign raddr = (op_reg == OP_VICTIM) ? head_reg : frame_reg;

    lfr_ram #(.WIDTH(FW), .DEPTH(FRAMES)) u_next_ram (
        .clk   (clk),
        .we    (next_we),
        .waddr (next_waddr),
        .wdata (next_wdata),
        .re    (cmd.read),
        .raddr (raddr),
        .rdata (next_rd)
    );

    lfr_ram #(.WIDTH(FW), .DEPTH(FRAMES)) u_prev_ram (
        .clk   (clk),
        .we    (prev_we),
        .waddr (prev_waddr),
        .wdata (prev_wdata),
        .re    (cmd.read),
        .raddr (raddr),
        .rdata (prev_rd)
    );

    always_comb
    begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        length_next = length_reg;
        listed_next = listed_reg;
        next_we     = 1'b0;
        next_waddr  = tail_reg;
        next_wdata  = frame_reg;
        prev_we     = 1'b0;
        prev_waddr  = frame_reg;
        prev_wdata  = tail_reg;
        if (cmd.victim)
        begin
            head_next             = next_rd;
            length_next           = length_reg - 1'b1;
            listed_next[head_reg] = 1'b0;
        end
        else if (cmd.pin)
        begin
            next_waddr = prev_rd;
            next_wdata = next_rd;
            prev_waddr = next_rd;
            prev_wdata = prev_rd;
            if (frame_reg == head_reg)
            begin
                head_next = next_rd;
            end
            else
            begin
                next_we = 1'b1;
            end
            if (frame_reg == tail_reg)
            begin
                tail_next = prev_rd;
            end
            else
            begin
                prev_we = 1'b1;
            end
            length_next            = length_reg - 1'b1;
            listed_next[frame_reg] = 1'b0;
        end
        else if (cmd.unpin)
        begin
            if (empty)
            begin
                head_next = frame_reg;
            end
            else
            begin
                next_we = 1'b1;
                prev_we = 1'b1;
            end
            tail_next              = frame_reg;
            length_next            = length_reg + 1'b1;
            listed_next[frame_reg] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg <= '0;
            listed_reg <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            length_reg <= length_next;
            listed_reg <= listed_next;
            done_reg   <= cmd.finish;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg       <= opcode;
            frame_reg    <= FW'(XW'(frame));
            frame_ok_reg <= XW'(frame) < XW'(FRAMES);
        end
        head_reg <= head_next;
        tail_reg <= tail_next;
        if (cmd.finish)
        begin
            found_reg  <= cmd.victim;
            victim_reg <= cmd.victim ? FRAME_W'(XW'(head_reg)) : '0;
            count_reg  <= COUNT_W'(MW'(length_next));
        end
    end

    assign done         = done_reg;
    assign found        = found_reg;
    assign victim_frame = victim_reg;
    assign count        = count_reg;

    a_listed_matches_length: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(listed_reg) == int'(length_reg))
        else $error("Listed flags disagree with the list length.");

    a_length_bound: assert property (@(posedge clk) disable iff (!rst_n)
        length_reg <= LW'(FRAMES))
        else $error("List length exceeds the number of frames.");

    a_victim_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.victim |=> {1'b0, length_reg} + 1'b1 == {1'b0, $past(length_reg)})
        else $error("Victim removal did not shorten the list by one.");

endmodule
